>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge -> cons holds at the same edge
`define ECM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// ante holds at an edge -> cons holds after the delay given by dly
`define ECM_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("delayed check failed");

`endif

>>> src/ecm_pkg.sv
// Package for the elevation color map: widths, constants, classes and shared types.
`default_nettype none

package ecm_pkg;

    localparam int ECM_DATA_W        = 16;
    localparam int ECM_DIFF_W        = 16;
    localparam int ECM_CH_W          = 8;
    localparam int ECM_CFG_IDX_W     = 2;
    localparam int ECM_FRACTION_BITS = 16;

    // register indexes
    localparam logic [ECM_CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd0;
    localparam logic [ECM_CFG_IDX_W-1:0] CFG_SEA_LEVEL = 2'd1;
    localparam logic [ECM_CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

    localparam logic signed [ECM_DATA_W-1:0] MIN_LEVEL_RST = -16'sd11000;
    localparam logic signed [ECM_DATA_W-1:0] SEA_LEVEL_RST = 16'sd0;
    localparam logic signed [ECM_DATA_W-1:0] MAX_LEVEL_RST = 16'sd9000;

    // channel coefficients, 1.0 = 255
    localparam int CH_FULL     = 255;   // 1.0
    localparam int GREEN_FLAT  = 153;   // 0.6
    localparam int GREEN_BASE  = 306;   // 1.2
    localparam int GREEN_SLOPE = 459;   // 1.8
    localparam int RED_SLOPE   = 765;   // 3.0
    localparam int BLUE_BASE   = 510;   // 2.0

    typedef enum logic [2:0] {
        CLS_MISSING,
        CLS_LOW,
        CLS_WATER,
        CLS_HIGH,
        CLS_LAND
    } ecm_class_t;

    typedef struct packed {
        logic       valid;
        ecm_class_t cls;
    } ecm_tag_t;

    typedef struct packed {
        logic signed [ECM_DATA_W-1:0] min_level;
        logic signed [ECM_DATA_W-1:0] sea_level;
        logic signed [ECM_DATA_W-1:0] max_level;
    } ecm_levels_t;

    typedef struct packed {
        logic signed [ECM_DATA_W-1:0] elevation;
        logic                         is_missing;
    } ecm_request_t;

    typedef struct packed {
        logic [ECM_CH_W-1:0] red;
        logic [ECM_CH_W-1:0] green;
        logic [ECM_CH_W-1:0] blue;
        logic                opaque;
    } ecm_result_t;

endpackage

`default_nettype wire

>>> src/ecm_front.sv
// Entry stage: classifies the sample and forms the divider operands.
`default_nettype none

module ecm_front
    import ecm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire ecm_request_t          request,
    input  wire ecm_levels_t           levels,
    output ecm_tag_t                   tag,
    output logic [ECM_DIFF_W-1:0]      num,
    output logic [ECM_DIFF_W-1:0]      den
);

    logic signed [ECM_DATA_W:0] v_x;
    logic signed [ECM_DATA_W:0] lo_x;
    logic signed [ECM_DATA_W:0] sea_x;
    logic signed [ECM_DATA_W:0] hi_x;
    logic signed [ECM_DATA_W:0] water_num;
    logic signed [ECM_DATA_W:0] water_den;
    logic signed [ECM_DATA_W:0] land_num;
    logic signed [ECM_DATA_W:0] land_den;

    ecm_tag_t                tag_reg;
    ecm_tag_t                tag_next;
    logic [ECM_DIFF_W-1:0]   num_reg;
    logic [ECM_DIFF_W-1:0]   num_next;
    logic [ECM_DIFF_W-1:0]   den_reg;
    logic [ECM_DIFF_W-1:0]   den_next;

    assign v_x   = (ECM_DATA_W+1)'(request.elevation);
    assign lo_x  = (ECM_DATA_W+1)'(levels.min_level);
    assign sea_x = (ECM_DATA_W+1)'(levels.sea_level);
    assign hi_x  = (ECM_DATA_W+1)'(levels.max_level);

    assign water_num = v_x - lo_x;
    assign water_den = sea_x - lo_x;
    assign land_num  = v_x - sea_x;
    assign land_den  = hi_x - sea_x;

    always_comb
    begin
        tag_next.valid = accept;
        num_next       = '0;
        den_next       = ECM_DIFF_W'(1);
        priority if (request.is_missing)
        begin
            tag_next.cls = CLS_MISSING;
        end
        else if (v_x < lo_x)
        begin
            tag_next.cls = CLS_LOW;
        end
        else if (v_x < sea_x)
        begin
            tag_next.cls = CLS_WATER;
            num_next     = water_num[ECM_DIFF_W-1:0];
            den_next     = water_den[ECM_DIFF_W-1:0];
        end
        else if (v_x > hi_x)
        begin
            tag_next.cls = CLS_HIGH;
        end
        else
        begin
            tag_next.cls = CLS_LAND;
            // sea equal to max: fraction is zero
            if (land_den != '0)
            begin
                num_next = land_num[ECM_DIFF_W-1:0];
                den_next = land_den[ECM_DIFF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '{valid: 1'b0, cls: CLS_MISSING};
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign tag = tag_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

`default_nettype wire

>>> src/ecm_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module ecm_divider
    import ecm_pkg::*;
#(
    parameter int FRACTION_BITS = ECM_FRACTION_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ecm_tag_t               tag_in,
    input  wire logic [ECM_DIFF_W-1:0]  num,
    input  wire logic [ECM_DIFF_W-1:0]  den,
    output ecm_tag_t                    tag_out,
    output logic [FRACTION_BITS:0]      quot
);

    localparam int STEPS = FRACTION_BITS + 1;

    ecm_tag_t               tag_reg  [STEPS];
    logic [ECM_DIFF_W-1:0]  rem_reg  [STEPS];
    logic [ECM_DIFF_W-1:0]  den_reg  [STEPS];
    logic [FRACTION_BITS:0] quot_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        ecm_tag_t               tag_src;
        logic [ECM_DIFF_W-1:0]  rem_src;
        logic [ECM_DIFF_W-1:0]  den_src;
        logic [FRACTION_BITS:0] quot_src;
        logic [ECM_DIFF_W:0]    shifted;
        logic                   fits;
        logic [ECM_DIFF_W:0]    diff;
        logic [ECM_DIFF_W-1:0]  rem_next;
        logic [FRACTION_BITS:0] quot_next;

        if (k == 0)
        begin : g_first
            // numerator never exceeds the divisor: top bit set only when equal
            assign tag_src  = tag_in;
            assign rem_src  = num;
            assign den_src  = den;
            assign quot_src = '0;
            assign shifted  = {1'b0, rem_src};
        end
        else
        begin : g_next
            assign tag_src  = tag_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign quot_src = quot_reg[k-1];
            assign shifted  = {rem_src, 1'b0};
        end

        assign fits      = shifted >= {1'b0, den_src};
        assign diff      = shifted - {1'b0, den_src};
        assign rem_next  = fits ? diff[ECM_DIFF_W-1:0] : shifted[ECM_DIFF_W-1:0];
        assign quot_next = {quot_src[FRACTION_BITS-1:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '{valid: 1'b0, cls: CLS_MISSING};
            end
            else
            begin
                tag_reg[k] <= tag_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_src;
            quot_reg[k] <= quot_next;
        end
    end

    assign tag_out = tag_reg[STEPS-1];
    assign quot    = quot_reg[STEPS-1];

endmodule

`default_nettype wire

>>> src/ecm_shade.sv
// Color stages: scaled products of the fraction, then segment select and truncation.
`default_nettype none

module ecm_shade
    import ecm_pkg::*;
#(
    parameter int FRACTION_BITS = ECM_FRACTION_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ecm_tag_t               tag_in,
    input  wire logic [FRACTION_BITS:0] quot,
    output logic                        done,
    output ecm_result_t                 result
);

    localparam int F      = FRACTION_BITS;
    localparam int P255_W = F + 8;
    localparam int P459_W = F + 9;
    localparam int P765_W = F + 10;

    localparam logic [P459_W-1:0] G_BASE_FX = {9'(GREEN_BASE), {F{1'b0}}};
    localparam logic [P765_W-1:0] R_BASE_FX = {10'(RED_SLOPE), {F{1'b0}}};
    localparam logic [P765_W-1:0] B_BASE_FX = {10'(BLUE_BASE), {F{1'b0}}};

    localparam logic [ECM_CH_W-1:0] CH_ON  = ECM_CH_W'(CH_FULL);
    localparam logic [ECM_CH_W-1:0] CH_OFF = '0;

    logic [F+2:0]        t3;
    logic [P255_W-1:0]   p255_next;
    logic [P459_W-1:0]   p459_next;
    logic [P765_W-1:0]   p765_next;

    ecm_tag_t            tag_reg;
    logic [P255_W-1:0]   p255_reg;
    logic [P459_W-1:0]   p459_reg;
    logic [P765_W-1:0]   p765_reg;
    logic                seg_lo_reg;
    logic                seg_mid_reg;

    logic [P459_W-1:0]   green_diff;
    logic [P765_W-1:0]   red_diff;
    logic [P765_W-1:0]   blue_diff;

    logic                done_reg;
    ecm_result_t         result_reg;
    ecm_result_t         result_next;

    assign t3        = {quot, 1'b0} + (F+3)'(quot);
    assign p255_next = P255_W'(quot) * P255_W'(CH_FULL);
    assign p459_next = P459_W'(quot) * P459_W'(GREEN_SLOPE);
    assign p765_next = P765_W'(quot) * P765_W'(RED_SLOPE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '{valid: 1'b0, cls: CLS_MISSING};
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= tag_in;
            done_reg <= tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p255_reg    <= p255_next;
        p459_reg    <= p459_next;
        p765_reg    <= p765_next;
        seg_lo_reg  <= (t3[F+2:F] == '0);
        seg_mid_reg <= (t3[F+2:F+1] == '0);
        result_reg  <= result_next;
    end

    assign green_diff = G_BASE_FX - p459_reg;
    assign red_diff   = R_BASE_FX - p765_reg;
    assign blue_diff  = p765_reg - B_BASE_FX;

    always_comb
    begin
        result_next.opaque = 1'b1;
        unique case (tag_reg.cls)
            CLS_MISSING:
            begin
                result_next.red    = CH_ON;
                result_next.green  = CH_ON;
                result_next.blue   = CH_ON;
                result_next.opaque = 1'b0;
            end
            CLS_LOW:
            begin
                result_next.red   = CH_OFF;
                result_next.green = CH_OFF;
                result_next.blue  = CH_ON;
            end
            CLS_WATER:
            begin
                result_next.red   = CH_OFF;
                result_next.green = p255_reg[F+7:F];
                result_next.blue  = CH_ON;
            end
            CLS_HIGH:
            begin
                result_next.red   = CH_ON;
                result_next.green = CH_OFF;
                result_next.blue  = CH_ON;
            end
            CLS_LAND:
            begin
                priority if (seg_lo_reg)
                begin
                    result_next.red   = p765_reg[F+7:F];
                    result_next.green = ECM_CH_W'(GREEN_FLAT);
                    result_next.blue  = CH_OFF;
                end
                else if (seg_mid_reg)
                begin
                    result_next.red   = CH_ON;
                    result_next.green = green_diff[F+7:F];
                    result_next.blue  = CH_OFF;
                end
                else
                begin
                    result_next.red   = red_diff[F+7:F];
                    result_next.green = CH_OFF;
                    result_next.blue  = blue_diff[F+7:F];
                end
            end
            default:
            begin
                result_next.red   = CH_OFF;
                result_next.green = CH_OFF;
                result_next.blue  = CH_OFF;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> src/elevation_color_map.sv
// Top level of the elevation color map: level registers, pipeline and checks.
`default_nettype none
`include "assert_macros.svh"

// Takes one elevation request per clock: busy is always low, so a request is
// accepted whenever start is high. Each request gives one color on result,
// marked by a single-cycle done pulse; the receiver must take it in that cycle.
// A request passes through an entry stage, the divider that forms the
// normalized fraction, one quotient bit per pipeline stage, and two color
// stages. The level registers are read when a request enters, so write them
// only when no request is in flight.

module elevation_color_map
    import ecm_pkg::*;
#(
    parameter int FRACTION_BITS = ECM_FRACTION_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire ecm_request_t              request,
    output logic                           done,
    output ecm_result_t                    result,
    input  wire logic                      cfg_write,
    input  wire logic [ECM_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ECM_DATA_W-1:0]     cfg_data
);

    localparam int LATENCY = FRACTION_BITS + 4;

    ecm_levels_t            levels_reg;
    ecm_levels_t            levels_next;
    logic                   accept;

    ecm_tag_t               front_tag;
    logic [ECM_DIFF_W-1:0]  front_num;
    logic [ECM_DIFF_W-1:0]  front_den;
    ecm_tag_t               div_tag;
    logic [FRACTION_BITS:0] div_quot;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        levels_next = levels_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_LEVEL: levels_next.min_level = cfg_data;
                CFG_SEA_LEVEL: levels_next.sea_level = cfg_data;
                CFG_MAX_LEVEL: levels_next.max_level = cfg_data;
                default:       levels_next = levels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '{min_level: MIN_LEVEL_RST,
                            sea_level: SEA_LEVEL_RST,
                            max_level: MAX_LEVEL_RST};
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

    ecm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .levels  (levels_reg),
        .tag     (front_tag),
        .num     (front_num),
        .den     (front_den)
    );

    ecm_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (front_tag),
        .num     (front_num),
        .den     (front_den),
        .tag_out (div_tag),
        .quot    (div_quot)
    );

    ecm_shade #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_shade (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (div_tag),
        .quot   (div_quot),
        .done   (done),
        .result (result)
    );

    // every request comes out after the fixed latency, and nothing else does
    `ECM_ASSERT_DELAY(a_req_to_done, accept, LATENCY, done)
    `ECM_ASSERT_IMPLY(a_done_has_req, done, $past(accept, LATENCY))
    // a transparent result is always white
    `ECM_ASSERT_IMPLY(a_missing_white, done && !result.opaque,
        result.red == 8'hFF && result.green == 8'hFF && result.blue == 8'hFF)

endmodule

`default_nettype wire
